[rtl/rbb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_pkg
// Shared types, sizes and helpers for the RGB 3x3 box blur.
// ----------------------------------------------------------------------------
package rbb_pkg;

    localparam int MAX_WIDTH = 1024;
    localparam int ADDR_W    = $clog2(MAX_WIDTH);
    localparam int PIX_W     = 24;
    localparam int COL_W     = 11;
    localparam int ROW_W     = 13;   // one spare bit: drain walks one row past the frame
    localparam int CFG_IDX_W = 2;
    localparam int CFG_DAT_W = 12;

    // register map
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_WIDTH  = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FRAME_HEIGHT = 2'd1;

    localparam logic [10:0] WIDTH_RESET  = 11'd640;
    localparam logic [11:0] HEIGHT_RESET = 12'd480;

    typedef struct packed {
        logic       req_type;
        logic [7:0] red_in;
        logic [7:0] green_in;
        logic [7:0] blue_in;
    } pix_in_t;

    typedef struct packed {
        logic [7:0] red_out;
        logic [7:0] green_out;
        logic [7:0] blue_out;
        logic       end_of_frame;
    } pix_out_t;

    typedef enum logic [1:0] {
        DIV_BY_4,
        DIV_BY_6,
        DIV_BY_9
    } div_sel_t;

    // truncating divide of an 8-bit value by 4, 6 or 9 (reciprocal, exact below 256)
    function automatic logic [7:0] div_small(input logic [7:0] v, input div_sel_t sel);
        logic [15:0] prod;
        logic [7:0]  res;
        prod = 16'd0;
        res  = 8'd0;
        case (sel)
            DIV_BY_4: begin
                res = {2'b00, v[7:2]};
            end
            DIV_BY_6: begin
                prod = {8'd0, v} * 16'd171;
                res  = {2'b00, prod[15:10]};
            end
            DIV_BY_9: begin
                prod = {8'd0, v} * 16'd57;
                res  = {1'b0, prod[15:9]};
            end
            default: begin
                res = 8'd0;
            end
        endcase
        return res;
    endfunction

endpackage

[rtl/rbb_ram.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rbb_ram
// Simple dual-port RAM: one write port, one read port, registered read
// returning the old contents on a same-address collision.
// ----------------------------------------------------------------------------
module rbb_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 1024
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic                     re,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        if (re) begin
            rdata_reg <= mem[raddr];
        end
    end

    assign rdata = rdata_reg;

endmodule

[rtl/rgb_box_blur_3x3.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// rgb_box_blur_3x3
// Streaming 3x3 mean filter for RGB888 frames, clipped at the frame border.
// ----------------------------------------------------------------------------
// Usage:
//   s_* carries one word per pixel in raster order (req_type 0), or a drain
//   word (req_type 1). m_* returns one filtered pixel per word that completes
//   a neighbourhood; results trail the input by one row plus one pixel, so
//   after the last pixel of a frame frame_width+1 drain words release the
//   rest, the last one flagged end_of_frame. A drain word with nothing owed
//   is taken and dropped. A pixel arriving while results are owed drops them
//   and starts a new frame.
//   cfg_* writes frame_width (index 0) or frame_height (index 1); either
//   write restarts the raster position. cfg_ready is always high. Write only idle.
// Timing:
//   One word per cycle sustained while the output is not stalled. The line
//   stores are read in the accept cycle and registered with the word; the
//   window update, divide and sum then go into the output register.
// Reset / stall:
//   aresetn (synchronous, low) clears position, owed count and window, and
//   loads 640x480. Line stores are not cleared; border clipping keeps unwritten
//   entries out of every result. With m_valid high and m_ready low the whole
//   pipe holds and s_ready drops; otherwise s_ready stays high.
// ----------------------------------------------------------------------------
module rgb_box_blur_3x3 (
    input  logic                                   aclk,
    input  logic                                   aresetn,
    // pixel input
    input  logic                                   s_valid,
    output logic                                   s_ready,
    input  rbb_pkg::pix_in_t                       s_data,
    // filtered output
    output logic                                   m_valid,
    input  logic                                   m_ready,
    output rbb_pkg::pix_out_t                      m_data,
    // configuration writes
    input  logic                                   cfg_valid,
    output logic                                   cfg_ready,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]          cfg_index,
    input  logic [rbb_pkg::CFG_DAT_W-1:0]          cfg_data
);
    import rbb_pkg::*;

    // ---------------- configuration ----------------
    logic [10:0] width_cfg_reg;
    logic [11:0] height_cfg_reg;
    logic        cfg_wr;
    logic [10:0] eff_w;
    logic [11:0] eff_h;

    assign cfg_ready = 1'b1;
    assign cfg_wr    = cfg_valid && cfg_ready &&
                       ((cfg_index == CFG_FRAME_WIDTH) || (cfg_index == CFG_FRAME_HEIGHT));

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            width_cfg_reg  <= WIDTH_RESET;
            height_cfg_reg <= HEIGHT_RESET;
        end else if (cfg_valid && cfg_ready) begin
            if (cfg_index == CFG_FRAME_WIDTH) begin
                width_cfg_reg <= cfg_data[10:0];
            end
            if (cfg_index == CFG_FRAME_HEIGHT) begin
                height_cfg_reg <= cfg_data[11:0];
            end
        end
    end

    // clamp to the usable range
    always_comb begin
        if (width_cfg_reg < 11'd2) begin
            eff_w = 11'd2;
        end else if (width_cfg_reg > 11'(MAX_WIDTH)) begin
            eff_w = 11'(MAX_WIDTH);
        end else begin
            eff_w = width_cfg_reg;
        end
        eff_h = (height_cfg_reg < 12'd2) ? 12'd2 : height_cfg_reg;
    end

    // ---------------- pipe control ----------------
    // One enable for the whole pipe: it moves whenever the output slot frees.
    logic advance;
    logic accept;
    logic accept_live;   // accepted word that actually steps the raster

    assign advance = !m_valid || m_ready;
    assign s_ready = advance;
    assign accept  = s_valid && s_ready;

    // ---------------- stage 0: raster position ----------------
    logic [COL_W-1:0]  col_reg, col_next;
    logic [ROW_W-1:0]  row_reg, row_next;
    logic [COL_W-1:0]  pend_reg, pend_next;

    logic              is_drain, restart, ignore;
    logic [COL_W-1:0]  x0, cc0;
    logic [ROW_W-1:0]  y0, cr0;
    logic [COL_W-1:0]  x_inc;
    logic [ROW_W-1:0]  y_inc;
    logic [COL_W-1:0]  pend_dec;
    logic              have0, eof0, top0, bot0, left0, right0;
    logic [ADDR_W-1:0] idx0;
    logic [PIX_W-1:0]  px0;

    always_comb begin
        is_drain = s_data.req_type;
        restart  = !is_drain && (pend_reg != '0);   // pixel drops owed results
        ignore   = is_drain && (pend_reg == '0);
        x0       = restart ? '0 : col_reg;
        y0       = restart ? '0 : row_reg;
        px0      = is_drain ? '0 : {s_data.red_in, s_data.green_in, s_data.blue_in};
        idx0     = (x0 >= COL_W'(MAX_WIDTH)) ? ADDR_W'(MAX_WIDTH - 1) : x0[ADDR_W-1:0];

        // centre of the completed neighbourhood
        if (x0 != '0) begin
            have0 = (y0 >= ROW_W'(1));
            cr0   = y0 - ROW_W'(1);
            cc0   = x0 - COL_W'(1);
        end else begin
            have0 = (y0 >= ROW_W'(2));
            cr0   = y0 - ROW_W'(2);
            cc0   = eff_w - COL_W'(1);
        end
        top0   = (cr0 != '0);
        bot0   = (cr0 != ({1'b0, eff_h} - ROW_W'(1)));
        left0  = (cc0 != '0);
        right0 = (cc0 != (eff_w - COL_W'(1)));

        // advance position
        x_inc = x0 + COL_W'(1);
        y_inc = y0;
        if (x_inc >= eff_w) begin
            x_inc = '0;
            y_inc = y0 + ROW_W'(1);
        end
        pend_dec  = pend_reg - COL_W'(1);
        eof0      = 1'b0;
        col_next  = x_inc;
        row_next  = y_inc;
        pend_next = '0;
        if (is_drain) begin
            pend_next = pend_dec;
            if (pend_dec == '0) begin
                eof0     = 1'b1;
                col_next = '0;
                row_next = '0;
            end
        end else if (y_inc >= {1'b0, eff_h}) begin
            pend_next = eff_w + COL_W'(1);
        end
    end

    assign accept_live = accept && !ignore;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else if (cfg_wr) begin
            col_reg  <= '0;
            row_reg  <= '0;
            pend_reg <= '0;
        end else if (accept_live) begin
            col_reg  <= col_next;
            row_reg  <= row_next;
            pend_reg <= pend_next;
        end
    end

    // ---------------- line stores ----------------
    logic              s1_valid_reg;
    logic [PIX_W-1:0]  s1_px_reg;
    logic [ADDR_W-1:0] s1_idx_reg;
    logic              s1_have_reg, s1_eof_reg;
    logic              s1_top_reg, s1_bot_reg, s1_left_reg, s1_right_reg;
    logic              s1_fwd_reg;
    logic [PIX_W-1:0]  s1_fwd_up_reg, s1_fwd_mid_reg;

    logic              s1_fire;
    logic [PIX_W-1:0]  up_rd, mid_rd, up_eff, mid_eff;
    logic              fwd_hit;

    assign s1_fire = s1_valid_reg && advance;
    // same column written by stage 1 this cycle: RAM returns stale data
    assign fwd_hit = accept_live && s1_valid_reg && (s1_idx_reg == idx0);
    assign up_eff  = s1_fwd_reg ? s1_fwd_up_reg  : up_rd;
    assign mid_eff = s1_fwd_reg ? s1_fwd_mid_reg : mid_rd;

    rbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_upper (
        .aclk  (aclk),
        .we    (s1_fire),
        .waddr (s1_idx_reg),
        .wdata (mid_eff),
        .re    (accept_live),
        .raddr (idx0),
        .rdata (up_rd)
    );

    rbb_ram #(
        .WIDTH (PIX_W),
        .DEPTH (MAX_WIDTH)
    ) u_middle (
        .aclk  (aclk),
        .we    (s1_fire),
        .waddr (s1_idx_reg),
        .wdata (s1_px_reg),
        .re    (accept_live),
        .raddr (idx0),
        .rdata (mid_rd)
    );

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            s1_valid_reg <= 1'b0;
        end else if (advance) begin
            s1_valid_reg <= accept_live;
        end
    end

    always_ff @(posedge aclk) begin
        if (accept_live) begin
            s1_px_reg      <= px0;
            s1_idx_reg     <= idx0;
            s1_have_reg    <= have0;
            s1_eof_reg     <= eof0;
            s1_top_reg     <= top0;
            s1_bot_reg     <= bot0;
            s1_left_reg    <= left0;
            s1_right_reg   <= right0;
            s1_fwd_reg     <= fwd_hit;
            s1_fwd_up_reg  <= mid_eff;
            s1_fwd_mid_reg <= s1_px_reg;
        end
    end

    // ---------------- stage 1: window, divide, sum ----------------
    // window index = row*3 + col, col 2 newest
    logic [PIX_W-1:0] win_reg  [9];
    logic [PIX_W-1:0] win_next [9];
    div_sel_t         dsel;
    logic [8:0]       use_cell;
    logic [7:0]       sum_r, sum_g, sum_b;

    always_comb begin
        for (int k = 0; k < 9; k++) begin
            win_next[k] = win_reg[k];
        end
        for (int r = 0; r < 3; r++) begin
            win_next[r*3]     = win_reg[r*3 + 1];
            win_next[r*3 + 1] = win_reg[r*3 + 2];
        end
        win_next[2] = up_eff;
        win_next[5] = mid_eff;
        win_next[8] = s1_px_reg;

        if ((s1_top_reg && s1_bot_reg) && (s1_left_reg && s1_right_reg)) begin
            dsel = DIV_BY_9;
        end else if ((s1_top_reg && s1_bot_reg) || (s1_left_reg && s1_right_reg)) begin
            dsel = DIV_BY_6;
        end else begin
            dsel = DIV_BY_4;
        end

        for (int r = 0; r < 3; r++) begin
            for (int c = 0; c < 3; c++) begin
                use_cell[r*3 + c] = !((r == 0 && !s1_top_reg) || (r == 2 && !s1_bot_reg) ||
                                      (c == 0 && !s1_left_reg) || (c == 2 && !s1_right_reg));
            end
        end

        sum_r = '0;
        sum_g = '0;
        sum_b = '0;
        for (int k = 0; k < 9; k++) begin
            if (use_cell[k]) begin
                sum_r = sum_r + div_small(win_next[k][23:16], dsel);
                sum_g = sum_g + div_small(win_next[k][15:8], dsel);
                sum_b = sum_b + div_small(win_next[k][7:0], dsel);
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= '0;
            end
        end else if (s1_fire) begin
            for (int k = 0; k < 9; k++) begin
                win_reg[k] <= win_next[k];
            end
        end
    end

    // ---------------- output register ----------------
    logic     m_valid_reg;
    pix_out_t m_data_reg;

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            m_valid_reg <= 1'b0;
        end else if (advance) begin
            m_valid_reg <= s1_valid_reg && s1_have_reg;
        end
    end

    always_ff @(posedge aclk) begin
        if (s1_fire && s1_have_reg) begin
            m_data_reg.red_out      <= sum_r;
            m_data_reg.green_out    <= sum_g;
            m_data_reg.blue_out     <= sum_b;
            m_data_reg.end_of_frame <= s1_eof_reg;
        end
    end

    assign m_valid = m_valid_reg;
    assign m_data  = m_data_reg;

    // ---------------- checks ----------------
    a_out_from_stage1: assert property (@(posedge aclk) disable iff (!aresetn)
        $rose(m_valid_reg) |-> $past(s1_valid_reg))
        else $error("result appeared without a stage 1 word");

    a_pend_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        pend_reg <= COL_W'(MAX_WIDTH + 1))
        else $error("owed result count out of range");

    a_col_bound: assert property (@(posedge aclk) disable iff (!aresetn)
        col_reg < eff_w)
        else $error("column position beyond frame width");

    a_fwd_needs_s1: assert property (@(posedge aclk) disable iff (!aresetn)
        accept_live && fwd_hit |=> s1_fwd_reg && s1_valid_reg)
        else $error("store bypass lost its word");

endmodule

[bench/blur_tb_pkg.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// blur_tb_pkg
// Word kinds on the pixel channel, shared by the bench top and the checker.
// ----------------------------------------------------------------------------
package blur_tb_pkg;

    typedef enum logic {
        REQ_PIXEL = 1'b0,
        REQ_DRAIN = 1'b1
    } req_kind_t;

endpackage

[bench/box_blur_checker.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// box_blur_checker
// Tracks the blur's raster position, line stores and window from the words
// seen on the pixel and register channels, and holds the filtered words owed to check the result channel.
// ----------------------------------------------------------------------------
module box_blur_checker (
    input  logic                            aclk,
    input  logic                            aresetn,
    input  logic                            s_valid,
    input  logic                            s_ready,
    input  rbb_pkg::pix_in_t                s_data,
    input  logic                            m_valid,
    input  logic                            m_ready,
    input  rbb_pkg::pix_out_t               m_data,
    input  logic                            cfg_valid,
    input  logic                            cfg_ready,
    input  logic [rbb_pkg::CFG_IDX_W-1:0]   cfg_index,
    input  logic [rbb_pkg::CFG_DAT_W-1:0]   cfg_data,
    output int                              results_owed,
    output int                              mismatches
);
    import rbb_pkg::*;
    import blur_tb_pkg::*;

    bit [23:0]   upper_line [MAX_WIDTH];
    bit [23:0]   middle_line [MAX_WIDTH];
    bit [23:0]   win [9];          // row*3 + col, col 2 newest
    int unsigned col_pos;
    int unsigned row_pos;
    int unsigned owed;
    bit [10:0]   width_reg;
    bit [11:0]   height_reg;
    pix_out_t    blurred_q [$];
    pix_out_t    want;

    function automatic logic [7:0] clipped_mean(input int sh, input bit top_in,
                                                input bit bot_in, input bit left_in,
                                                input bit right_in, input int unsigned n);
        int unsigned acc;
        acc = 0;
        for (int rr = 0; rr < 3; rr++) begin
            for (int c = 0; c < 3; c++) begin
                if (!((rr == 0 && !top_in) || (rr == 2 && !bot_in) ||
                      (c == 0 && !left_in) || (c == 2 && !right_in))) begin
                    acc += win[rr * 3 + c][sh +: 8] / n;
                end
            end
        end
        return acc[7:0];
    endfunction

    function automatic void apply_window(input pix_in_t word);
        bit [23:0]   px;
        bit [23:0]   up;
        bit [23:0]   mid;
        int unsigned w, h, x, y, cr, cc, n;
        bit          have, eof, top_in, bot_in, left_in, right_in;
        pix_out_t    res;
        w   = (width_reg < 2) ? 2 : ((width_reg > MAX_WIDTH) ? MAX_WIDTH : width_reg);
        h   = (height_reg < 2) ? 2 : height_reg;
        eof = 1'b0;
        if (word.req_type == REQ_DRAIN) begin
            if (owed == 0)
                return;
            px = '0;
        end else begin
            // pixel with results still owed: drop them, new frame
            if (owed != 0) begin
                owed    = 0;
                col_pos = 0;
                row_pos = 0;
            end
            px = {word.red_in, word.green_in, word.blue_in};
        end
        x  = col_pos;
        y  = row_pos;
        up = upper_line[x];
        mid = middle_line[x];
        upper_line[x]  = mid;
        middle_line[x] = px;
        for (int k = 0; k < 3; k++) begin
            win[k * 3]     = win[k * 3 + 1];
            win[k * 3 + 1] = win[k * 3 + 2];
        end
        win[2] = up;
        win[5] = mid;
        win[8] = px;
        // centre sits one row plus one pixel behind the newest pixel in raster order
        if (x >= 1) begin
            have = (y >= 1);
            cr   = y - 1;
            cc   = x - 1;
        end else begin
            have = (y >= 2);
            cr   = y - 2;
            cc   = w - 1;
        end
        x++;
        if (x >= w) begin
            x = 0;
            y++;
        end
        if (word.req_type == REQ_DRAIN) begin
            owed--;
            if (owed == 0) begin
                eof = 1'b1;
                x   = 0;
                y   = 0;
            end
        end else if (y >= h) begin
            owed = w + 1;
        end
        col_pos = x;
        row_pos = y;
        if (!have)
            return;
        top_in   = (cr != 0);
        bot_in   = (cr != h - 1);
        left_in  = (cc != 0);
        right_in = (cc != w - 1);
        n = (1 + top_in + bot_in) * (1 + left_in + right_in);
        res.red_out      = clipped_mean(16, top_in, bot_in, left_in, right_in, n);
        res.green_out    = clipped_mean(8, top_in, bot_in, left_in, right_in, n);
        res.blue_out     = clipped_mean(0, top_in, bot_in, left_in, right_in, n);
        res.end_of_frame = eof;
        blurred_q.push_back(res);
    endfunction

    function automatic void check_field(input string name, input logic [7:0] exp_v,
                                        input logic [7:0] got_v);
        if (got_v !== exp_v) begin
            $error("%s: expected %0d, got %0d", name, exp_v, got_v);
            mismatches++;
        end
    endfunction

    always @(posedge aclk) begin
        if (!aresetn) begin
            width_reg  = WIDTH_RESET;
            height_reg = HEIGHT_RESET;
            col_pos    = 0;
            row_pos    = 0;
            owed       = 0;
            mismatches = 0;
            foreach (win[k])
                win[k] = '0;
            blurred_q.delete();
        end else begin
            if (cfg_valid && cfg_ready) begin
                case (cfg_index)
                    CFG_FRAME_WIDTH: begin
                        width_reg = cfg_data[10:0];
                        col_pos   = 0;
                        row_pos   = 0;
                        owed      = 0;
                    end
                    CFG_FRAME_HEIGHT: begin
                        height_reg = cfg_data;
                        col_pos    = 0;
                        row_pos    = 0;
                        owed       = 0;
                    end
                    default: begin
                    end
                endcase
            end
            if (m_valid && m_ready) begin
                if (blurred_q.size() == 0) begin
                    $error("filtered word with none owed: r %0d g %0d b %0d eof %0d",
                           m_data.red_out, m_data.green_out, m_data.blue_out,
                           m_data.end_of_frame);
                    mismatches++;
                end else begin
                    want = blurred_q.pop_front();
                    check_field("red_out", want.red_out, m_data.red_out);
                    check_field("green_out", want.green_out, m_data.green_out);
                    check_field("blue_out", want.blue_out, m_data.blue_out);
                    check_field("end_of_frame", {7'd0, want.end_of_frame},
                                {7'd0, m_data.end_of_frame});
                end
            end
            if (s_valid && s_ready)
                apply_window(s_data);
        end
        results_owed <= blurred_q.size();
    end

endmodule

[bench/testbench.sv]
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Frame stimulus and verdict for rgb_box_blur_3x3; checking is in the checker.
// ----------------------------------------------------------------------------
// A short directed run covers the corner, edge and interior divisors, channel
// extremes, register values below range and with unused high bits, a drain
// with nothing owed and a pixel cutting a drain short. Random phases then
// program a small frame size and stream whole frames with random pixels,
// mostly well formed, with stray drains, cut-short drains and truncated
// frames mixed in. A few cut-short frames at the register extremes finish
// the run.
// ----------------------------------------------------------------------------
module testbench;
    import rbb_pkg::*;
    import blur_tb_pkg::*;

    localparam int WATCHDOG_LIMIT = 2000;  // quiet cycles before the watchdog fails the run
    localparam int RANDOM_ITEMS   = 500;
    localparam int SETTLE_CYCLES  = 4;     // extra wait once the owed results are out
    localparam int END_CYCLES     = 8;

    logic                  aclk      = 1'b0;
    logic                  aresetn   = 1'b0;
    logic                  s_valid   = 1'b0;
    logic                  s_ready;
    pix_in_t               s_data    = '0;
    logic                  m_valid;
    logic                  m_ready   = 1'b0;
    pix_out_t              m_data;
    logic                  cfg_valid = 1'b0;
    logic                  cfg_ready;
    logic [CFG_IDX_W-1:0]  cfg_index = '0;
    logic [CFG_DAT_W-1:0]  cfg_data  = '0;
    int                    results_owed;
    int                    mismatches;

    // frame size in force and drains still worth sending
    int unsigned cur_w;
    int unsigned cur_h;
    int unsigned owed_drains;
    int unsigned counted_items;
    bit          no_gaps;
    int unsigned quiet_cycles = 0;
    int unsigned ready_hold   = 0;
    int unsigned ready_pick;

    always #2 aclk = ~aclk;

    rgb_box_blur_3x3 i_dut (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .s_valid   (s_valid),
        .s_ready   (s_ready),
        .s_data    (s_data),
        .m_valid   (m_valid),
        .m_ready   (m_ready),
        .m_data    (m_data),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data)
    );

    box_blur_checker i_checker (
        .aclk         (aclk),
        .aresetn      (aresetn),
        .s_valid      (s_valid),
        .s_ready      (s_ready),
        .s_data       (s_data),
        .m_valid      (m_valid),
        .m_ready      (m_ready),
        .m_data       (m_data),
        .cfg_valid    (cfg_valid),
        .cfg_ready    (cfg_ready),
        .cfg_index    (cfg_index),
        .cfg_data     (cfg_data),
        .results_owed (results_owed),
        .mismatches   (mismatches)
    );

    // Result side back-pressure: short random holds of ready high or low,
    // now and then a long stall, and now and then a long stall-free stretch.
    always @(posedge aclk) begin
        if (ready_hold != 0) begin
            ready_hold <= ready_hold - 1;
        end else begin
            ready_pick = $urandom_range(0, 99);
            if (ready_pick < 5) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(100, 300);
            end else if (ready_pick < 65) begin
                m_ready    <= 1'b1;
                ready_hold <= $urandom_range(0, 3);
            end else if (ready_pick < 95) begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(0, 3);
            end else begin
                m_ready    <= 1'b0;
                ready_hold <= $urandom_range(8, 40);
            end
        end
    end

    // Watchdog: any handshake on any channel counts as progress.
    always @(posedge aclk) begin
        if ((s_valid && s_ready) || (m_valid && m_ready) || (cfg_valid && cfg_ready)) begin
            quiet_cycles <= 0;
        end else begin
            quiet_cycles <= quiet_cycles + 1;
            if (quiet_cycles == WATCHDOG_LIMIT) begin
                $display("[FAIL] regression broken");
                $finish;
            end
        end
    end

    // Channel value: mostly uniform, sometimes pinned to an extreme.
    function automatic logic [7:0] rand_channel();
        int unsigned p;
        p = $urandom_range(0, 9);
        if (p == 0)
            return 8'd0;
        if (p == 1)
            return 8'hFF;
        return 8'($urandom_range(0, 255));
    endfunction

    // One word on the pixel channel, after a random gap unless gaps are off.
    // Returns at the edge that accepts it, valid still high.
    task automatic send_word(input req_kind_t kind, input logic [7:0] red,
                             input logic [7:0] green, input logic [7:0] blue);
        pix_in_t     word;
        int unsigned gap;
        int unsigned p;
        word.req_type = kind;
        word.red_in   = red;
        word.green_in = green;
        word.blue_in  = blue;
        gap = 0;
        if (!no_gaps) begin
            p = $urandom_range(0, 99);
            if (p >= 98)
                gap = $urandom_range(20, 60);
            else if (p >= 90)
                gap = $urandom_range(4, 12);
            else if (p >= 60)
                gap = $urandom_range(1, 3);
        end
        if (gap != 0) begin
            s_valid <= 1'b0;
            repeat (gap) @(posedge aclk);
        end
        s_valid <= 1'b1;
        s_data  <= word;
        do @(posedge aclk); while (!s_ready);
        // drains with nothing owed are dropped by the block: not counted
        if (kind == REQ_PIXEL) begin
            owed_drains = 0;
            counted_items++;
        end else if (owed_drains != 0) begin
            owed_drains--;
            counted_items++;
        end
    endtask

    // Stop sending, let every owed result out, then give the pipe time to empty.
    task automatic wait_quiet(input int unsigned extra);
        s_valid <= 1'b0;
        @(posedge aclk);
        while (results_owed != 0) @(posedge aclk);
        repeat (extra) @(posedge aclk);
    endtask

    // Width then height, back to back; both writes restart the raster.
    task automatic program_frame(input logic [CFG_DAT_W-1:0] w_data,
                                 input logic [CFG_DAT_W-1:0] h_data);
        cfg_valid <= 1'b1;
        cfg_index <= CFG_FRAME_WIDTH;
        cfg_data  <= w_data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_index <= CFG_FRAME_HEIGHT;
        cfg_data  <= h_data;
        do @(posedge aclk); while (!cfg_ready);
        cfg_valid <= 1'b0;
        cur_w = w_data[10:0];
        if (cur_w < 2)
            cur_w = 2;
        if (cur_w > MAX_WIDTH)
            cur_w = MAX_WIDTH;
        cur_h = (h_data < 2) ? 2 : h_data;
        owed_drains = 0;
    endtask

    // One frame size, a few frames. The last frame may be cut short; the
    // next register write then aborts it.
    task automatic run_phase(input logic [CFG_DAT_W-1:0] w_data,
                             input logic [CFG_DAT_W-1:0] h_data, input int frames);
        int unsigned area;
        int unsigned sent;
        int unsigned p;
        wait_quiet(SETTLE_CYCLES);
        program_frame(w_data, h_data);
        no_gaps = ($urandom_range(0, 3) == 0);
        for (int f = 0; f < frames; f++) begin
            if ($urandom_range(0, 9) == 0) begin
                repeat ($urandom_range(1, 2))
                    send_word(REQ_DRAIN, rand_channel(), rand_channel(), rand_channel());
            end
            area = cur_w * cur_h;
            sent = area;
            if (f == frames - 1 && $urandom_range(0, 9) == 0)
                sent = $urandom_range(1, area - 1);
            repeat (sent)
                send_word(REQ_PIXEL, rand_channel(), rand_channel(), rand_channel());
            if (sent == area) begin
                owed_drains = cur_w + 1;
                p = $urandom_range(0, 99);
                if (p < 15) begin
                    // drain cut short: next pixel or register write drops the rest
                    repeat ($urandom_range(1, cur_w))
                        send_word(REQ_DRAIN, rand_channel(), rand_channel(), rand_channel());
                end else begin
                    repeat (cur_w + 1)
                        send_word(REQ_DRAIN, rand_channel(), rand_channel(), rand_channel());
                    if (p >= 90) begin
                        repeat ($urandom_range(1, 3))
                            send_word(REQ_DRAIN, rand_channel(), rand_channel(),
                                      rand_channel());
                    end
                end
            end
        end
    endtask

    initial begin
        logic [CFG_DAT_W-1:0] w_data;
        logic [CFG_DAT_W-1:0] h_data;
        int unsigned          p;

        repeat (2) @(posedge aclk);
        aresetn <= 1'b1;

        // --- directed ---
        // width 0 and height 1 both clamp to 2: a 2x2 frame, every pixel a corner
        program_frame(12'd0, 12'd1);
        send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);
        send_word(REQ_PIXEL, 8'h00, 8'h00, 8'h00);
        send_word(REQ_PIXEL, 8'hFF, 8'h00, 8'hFF);
        send_word(REQ_PIXEL, 8'h00, 8'hFF, 8'h00);
        owed_drains = cur_w + 1;
        repeat (3) send_word(REQ_DRAIN, 8'hFF, 8'hFF, 8'hFF);
        // nothing owed: taken and dropped
        send_word(REQ_DRAIN, 8'h00, 8'h00, 8'h00);

        // width with bit 11 set lands on 3: corners, edges and the one interior
        wait_quiet(SETTLE_CYCLES);
        program_frame(12'h803, 12'd3);
        for (int i = 0; i < 9; i++)
            send_word(REQ_PIXEL, 8'hFF, (i % 2 != 0) ? 8'hFF : 8'h00, 8'(i * 31));
        owed_drains = cur_w + 1;
        repeat (2) send_word(REQ_DRAIN, 8'h00, 8'hFF, 8'h00);
        // pixel while results are owed: starts a new frame, left open for the
        // register write below to abort
        send_word(REQ_PIXEL, 8'hFF, 8'hFF, 8'hFF);

        // --- random, mostly small frames ---
        counted_items = 0;
        while (counted_items < RANDOM_ITEMS) begin
            p = $urandom_range(0, 99);
            if (p < 6)
                w_data = 12'($urandom_range(0, 1));
            else if (p < 12)
                w_data = 12'h800 | 12'($urandom_range(2, 6));
            else
                w_data = 12'($urandom_range(2, 8));
            if ($urandom_range(0, 99) < 8)
                h_data = 12'($urandom_range(0, 1));
            else
                h_data = 12'($urandom_range(2, 6));
            run_phase(w_data, h_data, $urandom_range(1, 3));
        end

        // --- register extremes, cut-short frames ---
        // widest width clamps to the line store depth, tallest height
        wait_quiet(SETTLE_CYCLES);
        program_frame(12'h7FF, 12'hFFF);
        repeat (12) send_word(REQ_PIXEL, rand_channel(), rand_channel(), rand_channel());
        // narrow and tall: top rows of a very long frame
        wait_quiet(SETTLE_CYCLES);
        program_frame(12'd2, 12'hFFF);
        repeat (16) send_word(REQ_PIXEL, rand_channel(), rand_channel(), rand_channel());

        wait_quiet(END_CYCLES);
        if (mismatches == 0 && results_owed == 0)
            $display("[ OK ] regression clean");
        else
            $display("[FAIL] regression broken");
        $finish;
    end

endmodule
